[hdl/cdt_pkg.sv]
`timescale 1ns / 1ps

package cdt_pkg;

   // Field widths of the request and response words.
   localparam int unsigned YEAR_W    = 12;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned SECOND_W  = 6;
   localparam int unsigned SECS_W    = 32;
   localparam int unsigned DAYS_W    = 16;
   localparam int unsigned WDAY_W    = 3;
   localparam int unsigned TIME_W    = 22;
   localparam int unsigned DATE_W    = 24;

   // Number of register stages in the conversion pipeline.
   localparam int unsigned STAGES    = 5;

   // Calendar constants of the era-based day count.
   localparam int unsigned BASE_YEAR        = 2000;
   localparam int unsigned YEARS_PER_ERA    = 400;
   localparam int unsigned DAYS_PER_ERA     = 146097;
   localparam int unsigned EPOCH_SHIFT_DAYS = 719468;
   localparam int unsigned DAYS_PER_YEAR    = 365;
   localparam int unsigned SECS_PER_DAY     = 86400;
   localparam int unsigned SECS_PER_HOUR    = 3600;
   localparam int unsigned SECS_PER_MIN     = 60;
   localparam int unsigned DAYS_PER_WEEK    = 7;
   // An era is a whole number of weeks, and the epoch shift plus the Thursday
   // offset leaves the day of era plus this bias, taken modulo seven.
   localparam int unsigned ISO_BIAS         = 9;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } req_payload_type;

   typedef struct packed {
      logic [SECS_W-1:0] unix_seconds;
      logic [DAYS_W-1:0] days_since_epoch;
      logic [WDAY_W-1:0] iso_weekday;
      logic [TIME_W-1:0] time_word;
      logic [DATE_W-1:0] date_word;
   } rsp_payload_type;

   // Packed BCD clock words; the weekday slot of the date word is left zero.
   typedef struct packed {
      logic [TIME_W-1:0] time_word;
      logic [DATE_W-1:0] date_word;
   } bcd_words_type;

   // Tens digit in bits 8:4, units digit in bits 3:0. The tens digit comes
   // from a reciprocal multiply that is exact for every 8-bit value.
   function automatic logic [8:0] bcd_encode(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  tens;
      logic [7:0]  units;
      prod  = {8'd0, v} * 16'd205;
      tens  = prod[15:11];
      units = v - ({3'd0, tens} * 8'd10);
      return {tens, units[3:0]};
   endfunction

   // Days from March 1 to the first of the month, with the year starting in
   // March. January, February and month zero belong to the previous year.
   function automatic logic [8:0] march_day_base(input logic [MONTH_W-1:0] month);
      logic [8:0] base;
      case (month)
         4'd0:    base = 9'd275;
         4'd1:    base = 9'd306;
         4'd2:    base = 9'd337;
         4'd3:    base = 9'd0;
         4'd4:    base = 9'd31;
         4'd5:    base = 9'd61;
         4'd6:    base = 9'd92;
         4'd7:    base = 9'd122;
         4'd8:    base = 9'd153;
         4'd9:    base = 9'd184;
         4'd10:   base = 9'd214;
         4'd11:   base = 9'd245;
         4'd12:   base = 9'd275;
         4'd13:   base = 9'd306;
         4'd14:   base = 9'd337;
         4'd15:   base = 9'd367;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

[hdl/cdt_if.sv]
`timescale 1ns / 1ps

// Request channel: one calendar date and time per word.
interface cdt_req_if import cdt_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// Response channel: epoch counts and BCD clock words.
interface cdt_rsp_if import cdt_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[hdl/cdt_bcd_words.sv]
`timescale 1ns / 1ps

module cdt_bcd_words import cdt_pkg::*; (
   input  req_payload_type item,
   output bcd_words_type   words
);

   logic [7:0] year_off;
   logic [8:0] year_bcd;
   logic [8:0] month_bcd;
   logic [8:0] day_bcd;
   logic [8:0] hour_bcd;
   logic [8:0] minute_bcd;
   logic [8:0] second_bcd;

   // The year field carries the year offset from the base year, modulo 256.
   assign year_off   = item.year[7:0] - 8'(BASE_YEAR);
   assign year_bcd   = bcd_encode(year_off);
   assign month_bcd  = bcd_encode({4'd0, item.month});
   assign day_bcd    = bcd_encode({3'd0, item.day});
   assign hour_bcd   = bcd_encode({3'd0, item.hour});
   assign minute_bcd = bcd_encode({2'd0, item.minute});
   assign second_bcd = bcd_encode({2'd0, item.second});

   // Each digit pair is masked to the width of its slot in the word.
   assign words.time_word = {hour_bcd[5:0], 1'b0, minute_bcd[6:0], 1'b0, second_bcd[6:0]};
   assign words.date_word = {year_bcd[7:0], 3'd0, month_bcd[4:0], 2'b00, day_bcd[5:0]};

endmodule

[hdl/civil_datetime_to_epoch_and_bcd.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Word
// req_if    in         valid / ready    year, month, day, hour, minute, second
// rsp_if    out        valid / ready    unix_seconds, days_since_epoch,
//                                       iso_weekday, time_word, date_word
//
// Five register stages; a word accepted on req_if passes through stages 1 to 5
// to rsp_if; one word is taken every cycle unless a full pipeline stalls.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and req_if.ready falls only when all five stages hold words.
// Synchronous reset empties the pipeline; data registers are not reset.
module civil_datetime_to_epoch_and_bcd import cdt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdt_req_if.sink   req_if,
   cdt_rsp_if.source rsp_if
);

   typedef struct packed {
      logic [12:0]   y;
      logic [4:0]    era;
      logic [9:0]    doy;
      logic [16:0]   hms;
      bcd_words_type words;
   } s1_type;

   typedef struct packed {
      logic [8:0]    yoe;
      logic [21:0]   era_off;
      logic [9:0]    doy;
      logic [16:0]   hms;
      bcd_words_type words;
   } s2_type;

   typedef struct packed {
      logic [18:0]   doe;
      logic [21:0]   era_off;
      logic [16:0]   hms;
      bcd_words_type words;
   } s3_type;

   typedef struct packed {
      logic [21:0]   days;
      logic [5:0]    wsum;
      logic [16:0]   hms;
      bcd_words_type words;
   } s4_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] adv;

   s1_type          s1_ff, s1_in;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   s4_type          s4_ff, s4_in;
   rsp_payload_type s5_ff, s5_in;

   bcd_words_type words;

   // Stage advance chain from the output back to the input.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_if.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_if.ready = adv[0];
   assign rsp_if.valid = valid_ff[STAGES-1];
   assign rsp_if.data  = s5_ff;

   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_if.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   cdt_bcd_words u_bcd_words (
      .item  (req_if.data),
      .words (words)
   );

   // Stage 1: March-based year, era, day of year, seconds of day.
   always_comb begin
      logic [3:0] era_cnt;
      s1_in   = '0;
      s1_in.y = {1'b0, req_if.data.year} - ((req_if.data.month <= 4'd2) ? 13'd1 : 13'd0);
      era_cnt = '0;
      for (int k = 1; k <= 10; k++) begin
         era_cnt = era_cnt + {3'd0, (s1_in.y[11:0] >= 12'(k * YEARS_PER_ERA))};
      end
      s1_in.era = s1_in.y[12] ? 5'h1f : {1'b0, era_cnt};
      s1_in.doy = {1'b0, march_day_base(req_if.data.month)}
                + {5'd0, req_if.data.day} - 10'd1;
      s1_in.hms = ({12'd0, req_if.data.hour} * 17'(SECS_PER_HOUR))
                + ({11'd0, req_if.data.minute} * 17'(SECS_PER_MIN))
                + {11'd0, req_if.data.second};
      s1_in.words = words;
   end

   // Stage 2: year of era and the era's day offset from the epoch.
   always_comb begin
      logic [13:0] era_years;
      logic [13:0] yoe_full;
      s2_in     = '0;
      era_years = {{9{s1_ff.era[4]}}, s1_ff.era} * 14'(YEARS_PER_ERA);
      yoe_full  = {s1_ff.y[12], s1_ff.y} - era_years;
      s2_in.yoe = yoe_full[8:0];
      s2_in.era_off = ({{17{s1_ff.era[4]}}, s1_ff.era} * 22'(DAYS_PER_ERA))
                    - 22'(EPOCH_SHIFT_DAYS);
      s2_in.doy   = s1_ff.doy;
      s2_in.hms   = s1_ff.hms;
      s2_in.words = s1_ff.words;
   end

   // Stage 3: day of era with the leap day corrections.
   always_comb begin
      logic [1:0] cent;
      s3_in = '0;
      cent  = 2'(s2_ff.yoe >= 9'd100) + 2'(s2_ff.yoe >= 9'd200)
            + 2'(s2_ff.yoe >= 9'd300);
      s3_in.doe = ({10'd0, s2_ff.yoe} * 19'(DAYS_PER_YEAR))
                + {12'd0, s2_ff.yoe[8:2]} - {17'd0, cent}
                + {{9{s2_ff.doy[9]}}, s2_ff.doy};
      s3_in.era_off = s2_ff.era_off;
      s3_in.hms     = s2_ff.hms;
      s3_in.words   = s2_ff.words;
   end

   // Stage 4: day count, and an octal digit sum that keeps the value mod 7.
   always_comb begin
      logic [17:0] biased;
      s4_in      = '0;
      s4_in.days = s3_ff.era_off + {{3{s3_ff.doe[18]}}, s3_ff.doe};
      biased     = s3_ff.doe[17:0] + 18'(ISO_BIAS);
      s4_in.wsum = {3'd0, biased[17:15]} + {3'd0, biased[14:12]} + {3'd0, biased[11:9]}
                 + {3'd0, biased[8:6]} + {3'd0, biased[5:3]} + {3'd0, biased[2:0]};
      s4_in.hms   = s3_ff.hms;
      s4_in.words = s3_ff.words;
   end

   // Stage 5: Unix seconds, weekday and the final date word.
   always_comb begin
      logic [3:0]  fold;
      logic [3:0]  rem;
      logic [31:0] day_secs;
      s5_in    = '0;
      day_secs = {{10{s4_ff.days[21]}}, s4_ff.days} * 32'(SECS_PER_DAY);
      fold     = {1'b0, s4_ff.wsum[5:3]} + {1'b0, s4_ff.wsum[2:0]};
      rem      = (fold >= 4'(DAYS_PER_WEEK)) ? fold - 4'(DAYS_PER_WEEK) : fold;
      s5_in.unix_seconds     = day_secs + {15'd0, s4_ff.hms};
      s5_in.days_since_epoch = s4_ff.days[15:0];
      s5_in.iso_weekday      = rem[2:0] + 3'd1;
      s5_in.time_word        = s4_ff.words.time_word;
      s5_in.date_word        = s4_ff.words.date_word;
      s5_in.date_word[15:13] = rem[2:0] + 3'd1;
   end

   // Data registers load whenever their stage advances.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
      if (adv[4]) begin
         s5_ff <= s5_in;
      end
   end

   // A reset leaves nothing on the response side.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid after reset");

   // Back pressure only reaches the input once every stage is full.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (valid_ff == {STAGES{1'b1}}))
      else $error("input stalled with an empty stage");

   // The weekday never reads zero.
   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.data.iso_weekday != 3'd0))
      else $error("weekday out of range");

   // The date word carries the same weekday as the weekday field.
   a_weekday_match: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.data.date_word[15:13] == rsp_if.data.iso_weekday))
      else $error("date word weekday mismatch");

endmodule

[tb/civil_datetime_to_epoch_and_bcd_tb.sv]
`timescale 1ns / 1ps

module civil_datetime_to_epoch_and_bcd_tb;
   import cdt_pkg::*;

   // Calendar constants as signed 64-bit values, so that negative day counts
   // never fall into unsigned arithmetic.
   localparam longint ERA_YEARS     = YEARS_PER_ERA;
   localparam longint ERA_DAYS      = DAYS_PER_ERA;
   localparam longint EPOCH_SHIFT   = EPOCH_SHIFT_DAYS;
   localparam longint YEAR_DAYS     = DAYS_PER_YEAR;
   localparam longint DAY_SECS      = SECS_PER_DAY;
   localparam longint HOUR_SECS     = SECS_PER_HOUR;
   localparam longint MIN_SECS      = SECS_PER_MIN;
   localparam longint WEEK_DAYS     = DAYS_PER_WEEK;
   localparam longint FIRST_YEAR    = BASE_YEAR;

   localparam int PIPE_DEPTH       = STAGES;
   localparam int RANDOM_DATES     = 1500;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int MAX_REPORTS      = 10;
   localparam int CYCLE_LIMIT      = 1000000;

   typedef struct {
      req_payload_type word;
      bit              drain_first;
   } queued_date_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            src_valid  = 1'b0;
   req_payload_type src_word   = '0;
   logic            sink_ready = 1'b0;

   cdt_req_if req_if();
   cdt_rsp_if rsp_if();

   assign req_if.valid = src_valid;
   assign req_if.data  = src_word;
   assign rsp_if.ready = sink_ready;

   civil_datetime_to_epoch_and_bcd dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   queued_date_type pending_dates[$];
   rsp_payload_type awaited_stamps[$];

   int unsigned words_accepted = 0;
   int unsigned stamps_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   int unsigned src_gap        = 0;
   int unsigned src_phase_left = 0;
   bit          src_quiet      = 1'b0;
   int unsigned hold_left       = 0;
   int unsigned sink_phase_left = 0;
   bit          sink_quiet      = 1'b0;
   bit          long_hold       = 1'b0;
   bit          long_hold_done  = 1'b0;

   always #5 clock = ~clock;

   // Packed BCD of a small value: tens digit from bit 4 up, units in bits 3:0.
   function automatic logic [11:0] bcd_pair(input longint v);
      longint tens;
      longint units;
      tens  = v / 10;
      units = v % 10;
      return {tens[7:0], units[3:0]};
   endfunction

   // Epoch seconds, day count, weekday and BCD clock words of one date word.
   function automatic rsp_payload_type convert_datetime(input req_payload_type d);
      longint yr, mon, dy, hr, mn, sc;
      longint y, era, yoe, mp, doy, doe, days, w, secs, yy;
      logic [11:0] hr_bcd, mn_bcd, sc_bcd, yy_bcd, mon_bcd, dy_bcd;
      logic [2:0]  wday;
      rsp_payload_type r;
      yr  = d.year;
      mon = d.month;
      dy  = d.day;
      hr  = d.hour;
      mn  = d.minute;
      sc  = d.second;

      // The year starts in March, so January, February and month zero
      // belong to the year before.
      y    = yr - ((mon <= 2) ? 1 : 0);
      era  = ((y >= 0) ? y : y - (ERA_YEARS - 1)) / ERA_YEARS;
      yoe  = y - era * ERA_YEARS;
      mp   = (mon > 2) ? mon - 3 : mon + 9;
      doy  = (153 * mp + 2) / 5 + dy - 1;
      doe  = yoe * YEAR_DAYS + yoe / 4 - yoe / 100 + doy;
      days = era * ERA_DAYS + doe - EPOCH_SHIFT;

      // The epoch fell on a Thursday.
      w = (days + 3) % WEEK_DAYS;
      if (w < 0) begin
         w = w + WEEK_DAYS;
      end
      wday = w[2:0] + 3'd1;

      secs = days * DAY_SECS + hr * HOUR_SECS + mn * MIN_SECS + sc;
      yy   = yr - FIRST_YEAR;
      yy   = yy & 64'hFF;

      hr_bcd  = bcd_pair(hr);
      mn_bcd  = bcd_pair(mn);
      sc_bcd  = bcd_pair(sc);
      yy_bcd  = bcd_pair(yy);
      mon_bcd = bcd_pair(mon);
      dy_bcd  = bcd_pair(dy);

      r.unix_seconds     = secs[31:0];
      r.days_since_epoch = days[15:0];
      r.iso_weekday      = wday;
      r.time_word        = {hr_bcd[5:0], 1'b0, mn_bcd[6:0], 1'b0, sc_bcd[6:0]};
      r.date_word        = {yy_bcd[7:0], wday, mon_bcd[4:0], 2'b00, dy_bcd[5:0]};
      return r;
   endfunction

   // No idling half the time, otherwise mostly short gaps and a few long ones.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic add_date(input int y, input int mo, input int d, input int h,
                           input int mi, input int s, input bit drain);
      queued_date_type q;
      q.word.year        = y[YEAR_W-1:0];
      q.word.month       = mo[MONTH_W-1:0];
      q.word.day         = d[DAY_W-1:0];
      q.word.hour        = h[HOUR_W-1:0];
      q.word.minute      = mi[MINUTE_W-1:0];
      q.word.second      = s[SECOND_W-1:0];
      q.drain_first      = drain;
      pending_dates.push_back(q);
   endtask

   // Sender: offers queued dates, records each accepted word's prediction.
   always @(posedge clock) begin
      if (reset) begin
         src_valid      <= 1'b0;
         src_gap        <= 0;
         words_accepted <= 0;
         src_phase_left <= 0;
      end else begin
         if (src_valid && req_if.ready) begin
            awaited_stamps.push_back(convert_datetime(src_word));
            words_accepted <= words_accepted + 1;
         end

         // Alternate between stretches with and without idling.
         if (src_phase_left == 0) begin
            src_phase_left <= $urandom_range(30, 300);
            src_quiet      <= ($urandom_range(0, 3) == 0);
         end else begin
            src_phase_left <= src_phase_left - 1;
         end

         if (!src_valid || req_if.ready) begin
            if (src_gap != 0 && !long_hold) begin
               src_gap   <= src_gap - 1;
               src_valid <= 1'b0;
            end else if (pending_dates.size() == 0) begin
               src_valid <= 1'b0;
            end else if (pending_dates[0].drain_first &&
                         (src_valid || words_accepted != stamps_checked)) begin
               // Hold back until every word in flight has come out.
               src_valid <= 1'b0;
            end else begin
               src_valid <= 1'b1;
               src_word  <= pending_dates[0].word;
               pending_dates.pop_front();
               src_gap   <= src_quiet ? 0 : idle_length();
            end
         end
      end
   end

   // Receiver: checks each result word against the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         sink_ready      <= 1'b0;
         hold_left       <= 0;
         stamps_checked  <= 0;
         sink_phase_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            stamps_checked <= stamps_checked + 1;
            if (awaited_stamps.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MAX_REPORTS) begin
                  $display("unexpected word: secs=%h days=%h wday=%0d time=%h date=%h",
                           got.unix_seconds, got.days_since_epoch, got.iso_weekday,
                           got.time_word, got.date_word);
               end
            end else begin
               want = awaited_stamps.pop_front();
               if (got.unix_seconds !== want.unix_seconds ||
                   got.days_since_epoch !== want.days_since_epoch ||
                   got.iso_weekday !== want.iso_weekday ||
                   got.time_word !== want.time_word ||
                   got.date_word !== want.date_word) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < MAX_REPORTS) begin
                     $display("word %0d expected: secs=%h days=%h wday=%0d time=%h date=%h",
                              stamps_checked, want.unix_seconds, want.days_since_epoch,
                              want.iso_weekday, want.time_word, want.date_word);
                     $display("word %0d actual:   secs=%h days=%h wday=%0d time=%h date=%h",
                              stamps_checked, got.unix_seconds, got.days_since_epoch,
                              got.iso_weekday, got.time_word, got.date_word);
                  end
               end
            end
         end

         if (sink_phase_left == 0) begin
            sink_phase_left <= $urandom_range(30, 300);
            sink_quiet      <= ($urandom_range(0, 3) == 0);
         end else begin
            sink_phase_left <= sink_phase_left - 1;
         end

         // One long back-pressure stretch fills the pipeline.
         if (!long_hold_done && stamps_checked == LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            long_hold      <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES;
            sink_ready     <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            sink_ready <= 1'b0;
         end else begin
            long_hold  <= 1'b0;
            sink_ready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 3) == 0) begin
               hold_left <= idle_length();
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int y, mo, d, h, mi, s;
      // Directed dates: range edges, leap days, malformed fields, wraps.
      add_date(2000,  1,  1,  0,  0,  0, 1'b0);
      add_date(2099, 12, 31, 23, 59, 59, 1'b0);
      add_date(2000,  2, 29, 12, 30, 30, 1'b0);
      add_date(2024,  2, 29,  6,  7,  8, 1'b0);
      add_date(2023,  2, 31, 10, 20, 30, 1'b0);
      add_date(2024,  3,  0,  1,  2,  3, 1'b0);
      add_date(2050,  0, 15,  4,  5,  6, 1'b0);
      add_date(2050, 13,  1,  7,  8,  9, 1'b0);
      add_date(2050, 14, 28, 11, 12, 13, 1'b0);
      add_date(2050, 15, 31, 14, 15, 16, 1'b0);
      add_date(1970,  1,  1,  0,  0,  0, 1'b0);
      add_date(1969, 12, 31, 23, 59, 59, 1'b0);
      add_date(   0,  1,  1,  0,  0,  0, 1'b0);
      add_date(   0,  0,  0,  0,  0,  0, 1'b0);
      add_date(4095, 15, 31, 31, 63, 63, 1'b0);
      add_date(2100,  3,  1,  0,  0,  1, 1'b0);
      add_date(2038,  1, 19,  3, 14,  8, 1'b0);
      add_date(2106,  2,  7,  6, 28, 16, 1'b0);
      add_date(2010,  6, 15, 31, 63, 63, 1'b0);
      add_date(2255,  5,  5, 24, 60, 60, 1'b0);
      add_date(1999, 12, 31, 22, 45, 50, 1'b0);

      // Random dates: mostly in range, some with every field fully random.
      for (int i = 0; i < RANDOM_DATES; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            y  = $urandom_range(2000, 2099);
            mo = $urandom_range(1, 12);
            d  = $urandom_range(1, 31);
            h  = $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            s  = $urandom_range(0, 59);
         end else begin
            y  = $urandom_range(0, 4095);
            mo = $urandom_range(0, 15);
            d  = $urandom_range(0, 31);
            h  = $urandom_range(0, 31);
            mi = $urandom_range(0, 63);
            s  = $urandom_range(0, 63);
         end
         add_date(y, mo, d, h, mi, s, (i == 600 || i == 1100));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_dates.size() != 0 || src_valid) begin
         @(posedge clock);
      end
      while (awaited_stamps.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_DEPTH * 4) @(posedge clock);

      if (mismatch_count == 0 && awaited_stamps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
